FILE: rtl/sit_pkg.sv
package sit_pkg;

  localparam int DEPTH    = 32;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int POS_BITS = 6;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic reject;
    logic compare;
    logic apply;
  } sit_ctl_t;

  typedef struct packed {
    logic rejected;
  } sit_sts_t;

endpackage

FILE: rtl/sit_ctrl.sv
module sit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sit_pkg::sit_sts_t sts_i,
  output sit_pkg::sit_ctl_t ctl_o
);
  import sit_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.rejected) begin
          ctl_o.reject = 1'b1;
          state_d      = S_RESP;
        end else begin
          ctl_o.compare = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.apply = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

endmodule

FILE: rtl/sit_datapath.sv
module sit_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sit_pkg::sit_ctl_t               ctl_i,
  output sit_pkg::sit_sts_t               sts_o,
  input  logic                            cmd_i,
  input  logic [sit_pkg::KEY_BITS-1:0]    size_key_i,
  input  logic [sit_pkg::ID_BITS-1:0]     entry_id_i,
  output logic [1:0]                      status_o,
  output logic [sit_pkg::POS_BITS-1:0]    position_o,
  output logic [sit_pkg::POS_BITS-1:0]    count_o
);
  import sit_pkg::*;

  logic                req_cmd_q;
  logic [KEY_BITS-1:0] req_key_q;
  logic [ID_BITS-1:0]  req_id_q;

  logic [KEY_BITS-1:0] key_q [DEPTH];
  logic [ID_BITS-1:0]  id_q  [DEPTH];
  logic [CNT_BITS-1:0] cnt_q;
  logic [DEPTH-1:0]    hit_q;

  status_e             res_status_q;
  logic [IDX_BITS-1:0] res_pos_q;

  logic [DEPTH-1:0]    hit_d;
  logic [DEPTH-1:0]    pre;
  logic [DEPTH-1:0]    first;
  logic [IDX_BITS-1:0] pos;
  logic                found;
  logic                is_ins;

  assign is_ins = (req_cmd_q == CMD_INSERT);
  assign sts_o.rejected = is_ins && ((req_key_q == '0) || (cnt_q == CNT_BITS'(DEPTH)));

  // insert: slots at or after the first larger key (or the first free slot)
  // remove: occupied slots whose id matches
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (is_ins) begin
        hit_d[i] = ((CNT_BITS'(i) < cnt_q) && (req_key_q < key_q[i]))
                   || (CNT_BITS'(i) == cnt_q);
      end else begin
        hit_d[i] = (CNT_BITS'(i) < cnt_q) && (id_q[i] == req_id_q);
      end
    end
  end

  always_comb begin
    pre[0]   = hit_q[0];
    first[0] = hit_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      pre[i]   = pre[i-1] | hit_q[i];
      first[i] = hit_q[i] & ~pre[i-1];
    end
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (first[i] ? IDX_BITS'(i) : '0);
    end
    found = pre[DEPTH-1];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_cmd_q <= cmd_i;
      req_key_q <= size_key_i;
      req_id_q  <= entry_id_i;
    end
    if (ctl_i.compare) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        key_q[i] <= '0;
        id_q[i]  <= '0;
      end
      cnt_q        <= '0;
      res_status_q <= ST_OK;
      res_pos_q    <= '0;
    end else if (ctl_i.reject) begin
      res_status_q <= (req_key_q == '0) ? ST_ZERO_KEY : ST_FULL;
      res_pos_q    <= '0;
    end else if (ctl_i.apply) begin
      if (!found) begin
        res_status_q <= ST_NOT_FOUND;
        res_pos_q    <= '0;
      end else begin
        res_status_q <= ST_OK;
        res_pos_q    <= pos;
        if (is_ins) begin
          cnt_q <= cnt_q + 1'b1;
          if (pre[0]) begin
            key_q[0] <= req_key_q;
            id_q[0]  <= req_id_q;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (first[i]) begin
              key_q[i] <= req_key_q;
              id_q[i]  <= req_id_q;
            end else if (pre[i]) begin
              key_q[i] <= key_q[i-1];
              id_q[i]  <= id_q[i-1];
            end
          end
        end else begin
          cnt_q <= cnt_q - 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (pre[i]) begin
              key_q[i] <= key_q[i+1];
              id_q[i]  <= id_q[i+1];
            end
          end
          if (pre[DEPTH-1]) begin
            key_q[DEPTH-1] <= '0;
            id_q[DEPTH-1]  <= '0;
          end
        end
      end
    end
  end

  assign status_o   = res_status_q;
  assign position_o = POS_BITS'(res_pos_q);
  assign count_o    = POS_BITS'(cnt_q);

endmodule

FILE: rtl/sorted_insert_remove_table.sv
// Sorted table of up to DEPTH (key, id) entries kept in ascending key order;
// equal keys keep arrival order. cmd 0 inserts, cmd 1 removes the lowest slot
// holding the id. One request is handled at a time. A request that searches
// the table raises the result valid after the latch, the registered per-slot
// compare and the shift of all slots; a zero-key or full-table reject raises
// it after the latch and the reject check. A new request is taken the cycle
// after the result is accepted. Every result carries status, position (0
// unless ok) and the count after the operation. The table is empty after
// reset with no clearing pass.
module sorted_insert_remove_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [sit_pkg::KEY_BITS-1:0] size_key_i,
  input  logic [sit_pkg::ID_BITS-1:0]  entry_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [sit_pkg::POS_BITS-1:0] position_o,
  output logic [sit_pkg::POS_BITS-1:0] count_o
);
  import sit_pkg::*;

  sit_ctl_t ctl;
  sit_sts_t sts;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  sit_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .cmd_i      (cmd_i),
    .size_key_i (size_key_i),
    .entry_id_i (entry_id_i),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

  a_pos_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (position_o == '0))
    else $error("position not zero on failed request");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ($stable(count_o) && !out_valid_o))
    else $error("count changed on request acceptance");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result repeated");

endmodule
